FILE: design/sample_statistics_engine_core_assert.svh
// Assertion macros for the sample statistics engine.
`ifndef SAMPLE_STATISTICS_ENGINE_CORE_ASSERT_SVH
`define SAMPLE_STATISTICS_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTH
`define SSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SSE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`ifndef SYNTH
`define SSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/sse_pkg.sv
// Shared types and constants of the sample statistics engine.
`timescale 1ns / 1ps
package sse_pkg;

  localparam int BATCH_SIZE_DEF = 32;

  localparam int DIV_W  = 72;   // dividend and quotient width
  localparam int DVS_W  = 10;   // divisor width
  localparam int RAD_W  = 64;   // square root radicand width
  localparam int ROOT_W = 32;

  localparam logic [DVS_W-1:0] ERR_DIVISOR = 10'd600;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         sample_index;
    logic signed [31:0] deviation;
    logic [62:0]        squared_deviation;
    logic signed [31:0] batch_mean;
    logic [31:0]        std_dev;
    logic [31:0]        mean_error;
    logic signed [63:0] max_error;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             go;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

FILE: design/sse_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sse_div (
  input  logic             clk,
  input  logic             rst_n,
  input  sse_pkg::div_req_t req,
  output sse_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(sse_pkg::DIV_W + 1);

  logic [sse_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [sse_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [sse_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [sse_pkg::DVS_W:0]   rem_sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[sse_pkg::DIV_W-1]};
    if (req.go) begin
      q_nxt   = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = sse_pkg::DVS_W'(rem_sh - {1'b0, dvs_r});
        q_nxt   = {q_r[sse_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[sse_pkg::DVS_W-1:0];
        q_nxt   = {q_r[sse_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(sse_pkg::DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

FILE: design/sse_sqrt.sv
// Integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module sse_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  sse_pkg::sqrt_req_t req,
  output sse_pkg::sqrt_rsp_t rsp
);

  localparam int REM_W = sse_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(sse_pkg::ROOT_W);

  logic [sse_pkg::RAD_W-1:0]  v_r, v_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [sse_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [REM_W-1:0]           rem_sh, trial;

  always_comb begin
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[REM_W-3:0], v_r[sse_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (req.go) begin
      v_nxt    = req.radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      v_nxt = {v_r[sse_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[sse_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[sse_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(sse_pkg::ROOT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

FILE: design/sample_statistics_engine_core.sv
// Load a batch of samples, then emit per-sample deviations with batch statistics.
// Load: each sample is stored, squared, then accumulated and compared, on one multiplier.
// Batch end of n samples: a first pass over them, 4 divides and 2 square roots.
// Results follow one sample at a time (memory read, difference, square, strobe).
// Results cannot be stalled. rst_n (synchronous) empties the batch; store contents persist.
`timescale 1ns / 1ps
`include "sample_statistics_engine_core_assert.svh"
module sample_statistics_engine_core #(
  parameter int BATCH_SIZE = sse_pkg::BATCH_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sse_pkg::in_item_t   in_data,
  output logic                out_valid,
  output sse_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(BATCH_SIZE + 1);
  localparam int IDX_W = $clog2(BATCH_SIZE);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LMUL   = 5'd1;
  localparam logic [4:0] S_LACC   = 5'd2;
  localparam logic [4:0] S_MEAN_G = 5'd3;
  localparam logic [4:0] S_MEAN_W = 5'd4;
  localparam logic [4:0] S_P_RD   = 5'd5;
  localparam logic [4:0] S_P_DIF  = 5'd6;
  localparam logic [4:0] S_P_MUL  = 5'd7;
  localparam logic [4:0] S_P_ACC  = 5'd8;
  localparam logic [4:0] S_VAR_G  = 5'd9;
  localparam logic [4:0] S_VAR_W  = 5'd10;
  localparam logic [4:0] S_SD_G   = 5'd11;
  localparam logic [4:0] S_SD_W   = 5'd12;
  localparam logic [4:0] S_VN_G   = 5'd13;
  localparam logic [4:0] S_VN_W   = 5'd14;
  localparam logic [4:0] S_ME_G   = 5'd15;
  localparam logic [4:0] S_ME_W   = 5'd16;
  localparam logic [4:0] S_ERR_G  = 5'd17;
  localparam logic [4:0] S_ERR_W  = 5'd18;

  logic [4:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic signed [39:0] sum_r, sum_nxt;
  logic signed [63:0] maxnum_r, maxnum_nxt;
  logic signed [31:0] s_r, s_nxt;
  logic               last_r, last_nxt;
  logic [31:0]        mul_op_r, mul_op_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic signed [31:0] mean_r, mean_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic [71:0]        sumsq_r, sumsq_nxt;
  logic [63:0]        var_r, var_nxt;
  logic [31:0]        sd_r, sd_nxt;
  logic [31:0]        me_r, me_nxt;
  logic signed [63:0] err_r, err_nxt;
  logic               pass_r, pass_nxt;
  logic               out_valid_r, out_valid_nxt;
  sse_pkg::out_item_t out_r, out_nxt;

  logic [31:0]        store_mem [BATCH_SIZE];
  logic [31:0]        rd_data_r;
  logic               accept;

  sse_pkg::div_req_t  div_req;
  sse_pkg::div_rsp_t  div_rsp;
  sse_pkg::sqrt_req_t sqrt_req;
  sse_pkg::sqrt_rsp_t sqrt_rsp;

  logic signed [63:0] s_ext, num;
  logic [39:0]        sum_mag;
  logic [63:0]        maxnum_mag;
  logic signed [32:0] d_calc;
  logic [32:0]        d_mag;
  logic signed [31:0] d_sat;
  logic               last_item;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE) || out_valid_r;

  sse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sse_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      store_mem[count_r[IDX_W-1:0]] <= in_data.sample;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_mem[k_r[IDX_W-1:0]];
  end

  always_comb begin
    s_ext      = {{32{s_r[31]}}, s_r};
    num        = (s_ext <<< 17) + (s_ext <<< 18) + $signed(prod_r);
    sum_mag    = sum_r[39] ? 40'(-sum_r) : sum_r;
    maxnum_mag = maxnum_r[63] ? 64'(-maxnum_r) : maxnum_r;
    d_calc     = {rd_data_r[31], rd_data_r} - {mean_r[31], mean_r};
    d_mag      = d_r[32] ? 33'(-d_r) : d_r;
    if (d_r[32] != d_r[31]) begin
      d_sat = d_r[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      d_sat = d_r[31:0];
    end
    last_item = (k_r + 1'b1) == count_r;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    maxnum_nxt    = maxnum_r;
    s_nxt         = s_r;
    last_nxt      = last_r;
    mul_op_nxt    = mul_op_r;
    prod_nxt      = prod_r;
    mean_nxt      = mean_r;
    d_nxt         = d_r;
    sumsq_nxt     = sumsq_r;
    var_nxt       = var_r;
    sd_nxt        = sd_r;
    me_nxt        = me_r;
    err_nxt       = err_r;
    pass_nxt      = pass_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    div_req.go        = 1'b0;
    div_req.dividend  = '0;
    div_req.divisor   = sse_pkg::DVS_W'(count_r);
    sqrt_req.go       = 1'b0;
    sqrt_req.radicand = var_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sum_nxt    = sum_r + {{8{in_data.sample[31]}}, in_data.sample};
          s_nxt      = in_data.sample;
          last_nxt   = in_data.last_sample;
          mul_op_nxt = in_data.sample[31] ? 32'(-in_data.sample) : in_data.sample;
          state_nxt  = S_LMUL;
        end
      end
      S_LMUL: begin
        prod_nxt  = mul_op_r * mul_op_r;
        state_nxt = S_LACC;
      end
      S_LACC: begin
        if (count_r == '0 || num > maxnum_r) begin
          maxnum_nxt = num;
        end
        count_nxt = count_r + 1'b1;
        if (last_r || (count_r + 1'b1) == CNT_W'(BATCH_SIZE)) begin
          state_nxt = S_MEAN_G;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MEAN_G: begin
        div_req.go       = 1'b1;
        div_req.dividend = 72'(sum_mag);
        state_nxt        = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (div_rsp.done) begin
          mean_nxt  = sum_r[39] ? 32'(-div_rsp.quotient[31:0]) : div_rsp.quotient[31:0];
          k_nxt     = '0;
          sumsq_nxt = '0;
          pass_nxt  = 1'b0;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        // read data lands in rd_data_r for the next state
        state_nxt = S_P_DIF;
      end
      S_P_DIF: begin
        d_nxt     = d_calc;
        state_nxt = S_P_MUL;
      end
      S_P_MUL: begin
        mul_op_nxt = d_mag[31:0];
        state_nxt  = S_P_ACC;
      end
      S_P_ACC: begin
        // square settles here; second pass emits, first pass sums
        prod_nxt = mul_op_r * mul_op_r;
        if (!pass_r) begin
          sumsq_nxt = sumsq_r + 72'(mul_op_r * mul_op_r);
          k_nxt     = k_r + 1'b1;
          state_nxt = last_item ? S_VAR_G : S_P_RD;
        end else begin
          out_valid_nxt             = 1'b1;
          out_nxt.sample_index      = 6'(k_r);
          out_nxt.deviation         = d_sat;
          out_nxt.squared_deviation = (mul_op_r * mul_op_r) > 64'h7FFF_FFFF_FFFF_FFFF ?
                                      {63{1'b1}} : 63'(mul_op_r * mul_op_r);
          out_nxt.batch_mean        = mean_r;
          out_nxt.std_dev           = sd_r;
          out_nxt.mean_error        = me_r;
          out_nxt.max_error         = err_r;
          out_nxt.last_result       = last_item;
          if (last_item) begin
            count_nxt = '0;
            sum_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_P_RD;
          end
        end
      end
      S_VAR_G: begin
        div_req.go       = 1'b1;
        div_req.dividend = sumsq_r;
        state_nxt        = S_VAR_W;
      end
      S_VAR_W: begin
        if (div_rsp.done) begin
          var_nxt   = (div_rsp.quotient[71:64] != '0) ? {64{1'b1}} : div_rsp.quotient[63:0];
          state_nxt = S_SD_G;
        end
      end
      S_SD_G: begin
        sqrt_req.go = 1'b1;
        state_nxt   = S_SD_W;
      end
      S_SD_W: begin
        if (sqrt_rsp.done) begin
          sd_nxt    = sqrt_rsp.root;
          state_nxt = S_VN_G;
        end
      end
      S_VN_G: begin
        div_req.go       = 1'b1;
        div_req.dividend = 72'(var_r);
        state_nxt        = S_VN_W;
      end
      S_VN_W: begin
        if (div_rsp.done) begin
          var_nxt   = div_rsp.quotient[63:0];
          state_nxt = S_ME_G;
        end
      end
      S_ME_G: begin
        sqrt_req.go = 1'b1;
        state_nxt   = S_ME_W;
      end
      S_ME_W: begin
        if (sqrt_rsp.done) begin
          me_nxt    = sqrt_rsp.root;
          state_nxt = S_ERR_G;
        end
      end
      S_ERR_G: begin
        div_req.go       = 1'b1;
        div_req.dividend = 72'(maxnum_mag);
        div_req.divisor  = sse_pkg::ERR_DIVISOR;
        state_nxt        = S_ERR_W;
      end
      S_ERR_W: begin
        if (div_rsp.done) begin
          err_nxt   = maxnum_r[63] ? 64'(-div_rsp.quotient[63:0]) : div_rsp.quotient[63:0];
          k_nxt     = '0;
          pass_nxt  = 1'b1;
          state_nxt = S_P_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      sum_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      sum_r       <= sum_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
    maxnum_r <= maxnum_nxt;
    s_r      <= s_nxt;
    last_r   <= last_nxt;
    mul_op_r <= mul_op_nxt;
    prod_r   <= prod_nxt;
    mean_r   <= mean_nxt;
    d_r      <= d_nxt;
    sumsq_r  <= sumsq_nxt;
    var_r    <= var_nxt;
    sd_r     <= sd_nxt;
    me_r     <= me_nxt;
    err_r    <= err_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SSE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `SSE_ASSERT_NXT(a_strobe_gap, out_valid, !out_valid, "result strobes in adjacent cycles")
  `SSE_ASSERT_IMP(a_dev_sq, out_valid, (out_data.deviation == 32'sd0) == (out_data.squared_deviation == 63'd0), "deviation and its square disagree")
  `SSE_ASSERT_IMP(a_idle_count, state_r == S_IDLE, count_r < CNT_W'(BATCH_SIZE), "store full while idle")

endmodule

FILE: dv/sample_statistics_engine_core_tb.sv
// Testbench for the sample statistics engine: batch loading, per-sample deviation results.
`timescale 1ns / 1ps
module sample_statistics_engine_core_tb;

  localparam int BATCH = sse_pkg::BATCH_SIZE_DEF;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sse_pkg::in_item_t in_data = '0;
  logic out_valid;
  sse_pkg::out_item_t out_data;

  bit failed = 1'b0;
  int idle_cycles = 0;

  // batch state of the predictor
  logic signed [31:0] held_samples[BATCH];
  int held_count = 0;
  logic signed [63:0] sum_acc = 0;
  logic signed [63:0] worst_err = 64'sh8000_0000_0000_0000;

  sse_pkg::out_item_t pending_results[$];

  always #6 clk = ~clk;

  sample_statistics_engine_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'h1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Fold one accepted sample into the batch; close the batch when flagged or full.
  task automatic absorb_sample(input sse_pkg::in_item_t it);
    logic signed [63:0] s, e, mean, d, ds;
    logic signed [127:0] prod;
    logic [63:0] ad, sq, var_q, sd, me;
    logic [127:0] sq_sum;
    sse_pkg::out_item_t r;
    s = it.sample;
    held_samples[held_count] = it.sample;
    held_count++;
    sum_acc += s;
    prod = s * 64'sd393216 + s * s;
    e = 64'(prod / 600);
    if (e > worst_err) worst_err = e;
    if (!it.last_sample && held_count < BATCH) return;
    mean = sum_acc / held_count;
    sq_sum = 0;
    for (int k = 0; k < held_count; k++) begin
      d = 64'(held_samples[k]) - mean;
      ad = d < 0 ? -d : d;
      sq_sum += ad * ad;
    end
    var_q = ((sq_sum / held_count) >> 64) != 0 ? '1 : 64'(sq_sum / held_count);
    sd = int_root(var_q);
    me = int_root(var_q / held_count);
    for (int k = 0; k < held_count; k++) begin
      d = 64'(held_samples[k]) - mean;
      ad = d < 0 ? -d : d;
      sq = ad * ad;
      ds = d > 64'sd2147483647 ? 64'sd2147483647 :
           d < -64'sd2147483648 ? -64'sd2147483648 : d;
      r.sample_index = k[5:0];
      r.deviation = ds[31:0];
      r.squared_deviation = sq[63] ? {63{1'b1}} : sq[62:0];
      r.batch_mean = mean[31:0];
      r.std_dev = sd > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sd[31:0];
      r.mean_error = me > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : me[31:0];
      r.max_error = worst_err;
      r.last_result = (k + 1 == held_count);
      pending_results.insert(pending_results.size(), r);
    end
    held_count = 0;
    sum_acc = 0;
    worst_err = 64'sh8000_0000_0000_0000;
  endtask

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, out_data);
        failed = 1'b1;
      end else begin
        sse_pkg::out_item_t x;
        x = pending_results.pop_front();
        if (out_data !== x) begin
          $display("%0t: result mismatch expected %h actual %h", $time, x, out_data);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sample_statistics_engine_core test failed");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [31:0] v, input logic lst);
    sse_pkg::in_item_t it;
    int gap;
    gap = $urandom_range(0, 17);
    // drop start over a pause; an item that follows at once keeps it high
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.sample = v;
    it.last_sample = lst;
    in_data <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    absorb_sample(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 2000) - 1000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 9)
                                     : 32'h8000_0000 + $urandom_range(0, 9);
      default: return 32'($urandom_range(0, 200000)) << 8;
    endcase
  endfunction

  task automatic test_extremes();
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(32'shFFFF_FFFF, 1'b1);
    send_sample(32'sh0000_0000, 1'b1);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    drain_results();
  endtask

  task automatic test_full_store();
    // no flag: the filling sample closes the batch
    for (int i = 0; i < BATCH; i++) send_sample(rand_sample(), 1'b0);
    drain_results();
  endtask

  task automatic test_random_batches();
    int sent, len;
    sent = 0;
    while (sent < 265) begin
      len = $urandom_range(0, 7) == 0 ? BATCH : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        send_sample(rand_sample(), i == len - 1 && len != BATCH);
      sent += len;
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_full_store();
    test_random_batches();
    repeat (50) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("sample_statistics_engine_core test passed");
    else
      $display("sample_statistics_engine_core test failed");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+design
design/sse_pkg.sv
design/sse_div.sv
design/sse_sqrt.sv
design/sample_statistics_engine_core.sv
dv/sample_statistics_engine_core_tb.sv
